[sv/md4_pkg.sv]
package md4_pkg;

   localparam logic [31:0] INIT_H0 = 32'h67452301;
   localparam logic [31:0] INIT_H1 = 32'hEFCDAB89;
   localparam logic [31:0] INIT_H2 = 32'h98BADCFE;
   localparam logic [31:0] INIT_H3 = 32'h10325476;
   localparam logic [31:0] K_ROUND1 = 32'h5A827999;
   localparam logic [31:0] K_ROUND2 = 32'h6ED9EBA1;
   localparam logic [7:0]  PAD_MARK = 8'h80;

   localparam logic [5:0]  LAST_STEP  = 6'd47;
   localparam logic [3:0]  LEN_LO_WORD = 4'd14;
   localparam logic [3:0]  LEN_HI_WORD = 4'd15;

   typedef logic [31:0] word_type;

   // message word used by a compression step
   function automatic logic [3:0] msg_word(input logic [5:0] step);
      logic [3:0] w;
      unique case (step[5:4])
         2'd0:    w = step[3:0];
         2'd1:    w = {step[1:0], step[3:2]};
         default: w = {step[0], step[1], step[2], step[3]};
      endcase
      return w;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] pos);
      logic [4:0] s;
      unique case ({rnd, pos})
         4'h0:    s = 5'd3;
         4'h1:    s = 5'd7;
         4'h2:    s = 5'd11;
         4'h3:    s = 5'd19;
         4'h4:    s = 5'd3;
         4'h5:    s = 5'd5;
         4'h6:    s = 5'd9;
         4'h7:    s = 5'd13;
         4'h8:    s = 5'd3;
         4'h9:    s = 5'd9;
         4'hA:    s = 5'd11;
         default: s = 5'd15;
      endcase
      return s;
   endfunction

endpackage

[sv/md4_req_if.sv]
interface md4_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

[sv/md4_rsp_if.sv]
interface md4_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[sv/md4_message_digest_core.sv]
// Input: a word that does not complete a block is absorbed without leaving idle; a word that
//   completes a 64-byte block holds the input through the 48 steps and the chaining add.
// Final word: the pad mark and fill writes and one or two compressions of 48 steps each,
//   then four digest words, one per cycle while the sink is ready.
// One MD4 step per cycle through a single shared adder/rotator.
// Reset (synchronous): initial chaining words, empty buffer count, zero block count.
module md4_message_digest_core (
   input  logic              clock,
   input  logic              reset,
   md4_req_if.sink           req_ch,
   md4_rsp_if.source         rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_ADD,
      ST_MARK,
      ST_FILL,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   md4_pkg::word_type h_ff [4];
   md4_pkg::word_type h_in [4];
   md4_pkg::word_type a_ff, b_ff, c_ff, d_ff;
   md4_pkg::word_type a_in, b_in, c_in, d_in;
   md4_pkg::word_type buf_ff [16];

   logic [5:0]  pos_ff, pos_in;
   logic [54:0] blocks_ff, blocks_in;
   logic [5:0]  step_ff, step_in;
   logic [3:0]  pw_ff, pw_in;
   logic [1:0]  idx_ff, idx_in;
   logic        fin_ff, fin_in;
   logic        extra_ff, extra_in;
   logic        pend_ff, pend_in;
   logic [63:0] len_ff, len_in;

   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [3:0]  wr_be;
   logic [31:0] wr_data;
   logic        start_comp;

   logic [1:0]  rnd;
   md4_pkg::word_type f_val, k_val, x_val, sum, t_val;
   logic [4:0]  rot;
   logic [63:0] rot_wide;

   logic        req_fire, rsp_fire;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == ST_OUT);
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign rsp_ch.digest_word = h_ff[idx_ff];
   assign rsp_ch.word_index  = idx_ff;
   assign rsp_ch.last_word   = (idx_ff == 2'd3);

   // step datapath
   assign rnd   = step_ff[5:4];
   assign x_val = buf_ff[md4_pkg::msg_word(step_ff)];
   always_comb begin
      unique case (rnd)
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = '0;
         end
         2'd1: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = md4_pkg::K_ROUND1;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = md4_pkg::K_ROUND2;
         end
      endcase
   end
   assign sum      = a_ff + f_val + x_val + k_val;
   assign rot      = md4_pkg::rot_amount(rnd, step_ff[1:0]);
   assign rot_wide = {sum, sum} << rot;
   assign t_val    = rot_wide[63:32];

   always_comb begin
      state_in  = state_ff;
      h_in      = h_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      pos_in    = pos_ff;
      blocks_in = blocks_ff;
      step_in   = step_ff;
      pw_in     = pw_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      extra_in  = extra_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[5:2];
      wr_be     = '0;
      wr_data   = '0;
      start_comp = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.byte_present) begin
                  wr_en   = 1'b1;
                  wr_be   = 4'b0001 << pos_ff[1:0];
                  wr_data = {4{req_ch.data_byte}};
                  pos_in  = pos_ff + 6'd1;
                  if (pos_ff == 6'd63) begin
                     start_comp = 1'b1;
                     pend_in    = req_ch.end_of_message;
                  end else if (req_ch.end_of_message) begin
                     state_in = ST_MARK;
                  end
               end else if (req_ch.end_of_message) begin
                  state_in = ST_MARK;
               end
            end
         end
         ST_MARK: begin
            len_in   = {blocks_ff, pos_ff, 3'b000};
            fin_in   = 1'b1;
            extra_in = (pos_ff[5:3] == 3'b111);
            wr_en    = 1'b1;
            wr_be    = 4'b1111 << pos_ff[1:0];
            wr_data  = {24'd0, md4_pkg::PAD_MARK} << {pos_ff[1:0], 3'b000};
            if (pos_ff[5:2] == 4'd15) begin
               start_comp = 1'b1;
            end else begin
               pw_in    = pos_ff[5:2] + 4'd1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = pw_ff;
            wr_be   = 4'b1111;
            if (!extra_ff && pw_ff == md4_pkg::LEN_LO_WORD) begin
               wr_data = len_ff[31:0];
            end else if (!extra_ff && pw_ff == md4_pkg::LEN_HI_WORD) begin
               wr_data = len_ff[63:32];
            end
            pw_in = pw_ff + 4'd1;
            if (pw_ff == 4'd15) begin
               start_comp = 1'b1;
            end
         end
         ST_COMP: begin
            a_in    = d_ff;
            b_in    = t_val;
            c_in    = b_ff;
            d_in    = c_ff;
            step_in = step_ff + 6'd1;
            if (step_ff == md4_pkg::LAST_STEP) begin
               step_in  = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0]   = h_ff[0] + a_ff;
            h_in[1]   = h_ff[1] + b_ff;
            h_in[2]   = h_ff[2] + c_ff;
            h_in[3]   = h_ff[3] + d_ff;
            blocks_in = blocks_ff + 55'd1;
            pos_in    = '0;
            if (pend_ff) begin
               pend_in  = 1'b0;
               state_in = ST_MARK;
            end else if (fin_ff && extra_ff) begin
               extra_in = 1'b0;
               pw_in    = '0;
               state_in = ST_FILL;
            end else if (fin_ff) begin
               fin_in   = 1'b0;
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  h_in[0]   = md4_pkg::INIT_H0;
                  h_in[1]   = md4_pkg::INIT_H1;
                  h_in[2]   = md4_pkg::INIT_H2;
                  h_in[3]   = md4_pkg::INIT_H3;
                  blocks_in = '0;
                  pos_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (start_comp) begin
         a_in     = h_ff[0];
         b_in     = h_ff[1];
         c_in     = h_ff[2];
         d_in     = h_ff[3];
         step_in  = '0;
         state_in = ST_COMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         h_ff[0]   <= md4_pkg::INIT_H0;
         h_ff[1]   <= md4_pkg::INIT_H1;
         h_ff[2]   <= md4_pkg::INIT_H2;
         h_ff[3]   <= md4_pkg::INIT_H3;
         a_ff      <= '0;
         b_ff      <= '0;
         c_ff      <= '0;
         d_ff      <= '0;
         pos_ff    <= '0;
         blocks_ff <= '0;
         step_ff   <= '0;
         pw_ff     <= '0;
         idx_ff    <= '0;
         fin_ff    <= 1'b0;
         extra_ff  <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         h_ff      <= h_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         pos_ff    <= pos_in;
         blocks_ff <= blocks_in;
         step_ff   <= step_in;
         pw_ff     <= pw_in;
         idx_ff    <= idx_in;
         fin_ff    <= fin_in;
         extra_ff  <= extra_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      if (wr_en) begin
         for (int i = 0; i < 4; i++) begin
            if (wr_be[i]) begin
               buf_ff[wr_addr][i*8 +: 8] <= wr_data[i*8 +: 8];
            end
         end
      end
   end

   a_no_accept_while_out : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("input accepted while digest pending");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP) |-> (step_ff <= md4_pkg::LAST_STEP))
      else $error("step counter out of range");

   a_reinit_after_digest : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_word) |=>
         (h_ff[0] == md4_pkg::INIT_H0 && blocks_ff == '0 && pos_ff == '0 &&
          state_ff == ST_IDLE))
      else $error("state not reinitialized after digest");

   a_pending_end_only_in_comp : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_COMP || state_ff == ST_ADD))
      else $error("pending end outside compression");

endmodule

[tb/sv/md4_digest_checker.sv]
module md4_digest_checker (
   input  logic clock,
   input  logic reset,
   md4_req_if   req_ch,
   md4_rsp_if   rsp_ch,
   output int   error_count,
   output int   words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] START_A  = 32'h67452301;
   localparam logic [31:0] START_B  = 32'hEFCDAB89;
   localparam logic [31:0] START_C  = 32'h98BADCFE;
   localparam logic [31:0] START_D  = 32'h10325476;
   localparam logic [31:0] MAJ_K    = 32'h5A827999;
   localparam logic [31:0] PARITY_K = 32'h6ED9EBA1;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_SLOT = 6'd56;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   logic [31:0]  chain_h [4];
   logic [31:0]  msg_block [16];
   logic [5:0]   fill_count;
   logic [54:0]  block_count;
   digest_word_type expected_digest [$];
   int           fail_total = 0;

   function automatic int step_word(input int i);
      int j;
      int w;
      j = i % 16;
      case (i / 16)
         0:       w = j;
         1:       w = (j % 4) * 4 + j / 4;
         default: w = ((j & 1) << 3) | ((j & 2) << 1) | ((j & 4) >> 1) | ((j & 8) >> 3);
      endcase
      return w;
   endfunction

   function automatic int step_rotation(input int rnd, input int pos);
      int r;
      case (rnd)
         0:       r = (pos == 0) ? 3 : (pos == 1) ? 7 : (pos == 2) ? 11 : 19;
         1:       r = (pos == 0) ? 3 : (pos == 1) ? 5 : (pos == 2) ? 9 : 13;
         default: r = (pos == 0) ? 3 : (pos == 1) ? 9 : (pos == 2) ? 11 : 15;
      endcase
      return r;
   endfunction

   task automatic restore_initial();
      chain_h[0]  = START_A;
      chain_h[1]  = START_B;
      chain_h[2]  = START_C;
      chain_h[3]  = START_D;
      fill_count  = '0;
      block_count = '0;
   endtask

   task automatic compress_block();
      logic [31:0] v [4];
      logic [31:0] x, y, z, f, k, sum;
      int t;
      int s;
      for (int n = 0; n < 4; n++) v[n] = chain_h[n];
      for (int i = 0; i < 48; i++) begin
         t = (4 - (i % 4)) % 4;
         x = v[(t + 1) % 4];
         y = v[(t + 2) % 4];
         z = v[(t + 3) % 4];
         case (i / 16)
            0: begin
               f = (x & y) | (~x & z);
               k = 32'h0;
            end
            1: begin
               f = (x & y) | (x & z) | (y & z);
               k = MAJ_K;
            end
            default: begin
               f = x ^ y ^ z;
               k = PARITY_K;
            end
         endcase
         sum  = v[t] + f + msg_block[step_word(i)] + k;
         s    = step_rotation(i / 16, i % 4);
         v[t] = (sum << s) | (sum >> (32 - s));
      end
      for (int n = 0; n < 4; n++) chain_h[n] = chain_h[n] + v[n];
      block_count = block_count + 1'b1;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      msg_block[fill_count[5:2]][{fill_count[1:0], 3'b000} +: 8] = b;
      fill_count = fill_count + 1'b1;
      if (fill_count == 6'd0) compress_block();
   endtask

   task automatic finish_message();
      logic [63:0]     bit_length;
      digest_word_type entry;
      bit_length = {block_count, fill_count, 3'b000};
      absorb_byte(PAD_BYTE);
      // no room for the length: zero-fill and compress an extra block
      if (fill_count > LEN_SLOT) begin
         while (fill_count != 6'd0) absorb_byte(8'h00);
      end
      while (fill_count < LEN_SLOT) absorb_byte(8'h00);
      msg_block[14] = bit_length[31:0];
      msg_block[15] = bit_length[63:32];
      compress_block();
      for (int n = 0; n < 4; n++) begin
         entry.word  = chain_h[n];
         entry.index = 2'(n);
         entry.last  = (n == 3);
         expected_digest.push_back(entry);
      end
      restore_initial();
   endtask

   always @(posedge clock) begin
      digest_word_type want;
      if (reset) begin
         restore_initial();
         expected_digest.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.byte_present) absorb_byte(req_ch.data_byte);
            if (req_ch.end_of_message) finish_message();
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_digest.size() == 0) begin
               $display("%0t: unexpected digest word: expected none, got %h/%0d/%b", $time,
                        rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
               fail_total++;
            end else begin
               want = expected_digest.pop_front();
               if (rsp_ch.digest_word !== want.word || rsp_ch.word_index !== want.index ||
                   rsp_ch.last_word !== want.last) begin
                  $display("%0t: digest word mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           $time, want.word, want.index, want.last,
                           rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
                  fail_total++;
               end
            end
         end
      end
      error_count   <= fail_total;
      words_pending <= expected_digest.size();
   end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 370;
   localparam int QUIET_TAIL   = 40;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 200;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   words_pending;
   int   cycle_count = 0;
   int   words_sent = 0;
   bit   quiet = 1'b0;
   bit   rsp_hold_go = 1'b0;

   md4_req_if req_ch ();
   md4_rsp_if rsp_ch ();

   md4_message_digest_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   md4_digest_checker digest_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .words_pending (words_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d digest words outstanding", $time, words_pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // digest sink: random bursts of back-pressure plus one long hold-off
   initial begin
      int idle_left;
      int hold_left;
      bit hold_done;
      idle_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_hold_go && !hold_done && rsp_ch.valid) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [7:0] value, input logic present, input logic eom);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= value;
      req_ch.byte_present   <= present;
      req_ch.end_of_message <= eom;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (present || eom) words_sent++;
      if (words_sent >= RANDOM_WORDS - QUIET_TAIL) quiet <= 1'b1;
   endtask

   task automatic drain_digests();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   task automatic send_message();
      int  len;
      int  pick;
      bit  merged;
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
         len = $urandom_range(0, 16);
      end else if (pick < 16) begin
         case ($urandom_range(0, 7))
            0:       len = 55;
            1:       len = 56;
            2:       len = 57;
            3:       len = 63;
            4:       len = 64;
            5:       len = 65;
            6:       len = 119;
            default: len = 120;
         endcase
      end else begin
         len = $urandom_range(0, 130);
      end
      merged = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int n = 0; n < len; n++) begin
         if ($urandom_range(0, 15) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, merged && (n == len - 1));
      end
      if (!merged) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.data_byte      <= 8'h00;
      req_ch.byte_present   <= 1'b0;
      req_ch.end_of_message <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty message
      send_word(8'h00, 1'b0, 1'b1);
      // "abc", end on the last byte
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      // idle words in the middle, empty end word
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hA5, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b1);
      send_word(8'h3C, 1'b0, 1'b0);
      send_word(8'hFF, 1'b1, 1'b1);
      drain_digests();

      words_sent = 0;
      rsp_hold_go <= 1'b1;
      while (words_sent < RANDOM_WORDS) begin
         send_message();
         if (!quiet && $urandom_range(0, 7) == 0) drain_digests();
      end
      drain_digests();
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0 && words_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
sv/md4_pkg.sv
sv/md4_req_if.sv
sv/md4_rsp_if.sv
sv/md4_message_digest_core.sv
tb/sv/md4_digest_checker.sv
tb/sv/tb_top.sv
